[design/fdua_pkg.sv]
// shared types and constants for the full-duplex uart with busy alarm
`default_nettype none

package fdua_pkg;

    // request operation codes
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SEND  = 2'd1,
        OP_POP   = 2'd2,
        OP_ALARM = 2'd3
    } op_t;

    // transmitter phases
    typedef enum logic [2:0] {
        TX_IDLE   = 3'd0,
        TX_START  = 3'd1,
        TX_DATA   = 3'd2,
        TX_STOP   = 3'd3,
        TX_FINISH = 3'd4,
        TX_ALARM  = 3'd5
    } tx_phase_t;

    // receiver phases
    typedef enum logic [1:0] {
        RX_IDLE     = 2'd0,
        RX_HALF     = 2'd1,
        RX_DATA     = 2'd2,
        RX_STOPWAIT = 2'd3
    } rx_phase_t;

    // request strobe and operation handed to the transmitter and receiver
    typedef struct packed {
        logic fire;
        op_t  op;
    } item_ctl_t;

    localparam logic [7:0] BIT_PERIOD_RESET = 8'd208;
    localparam logic [3:0] DATA_BITS        = 4'd8;

endpackage

`default_nettype wire

[design/full_duplex_uart_with_alarm.sv]
// top level: request register, transmitter, receiver ring and result register
//
//  channel   signals                                          direction
//  request   in_valid, in_stall, operation, rx_line,          in (in_stall out)
//            data_byte, alarm_ticks
//  result    out_valid, out_stall, tx_line, tx_ready,         out (out_stall in)
//            rx_count, read_valid, read_byte, rejected
//  config    cfg_write, cfg_data (bit period in ticks)        in
//
// one request per cycle while the result is not stalled; each request waits in
// the request register and its result is loaded into the result register.
// the transmitter, receiver and ring pointers update as the request leaves
// the request register; the ring read data is registered at that same edge.
// reset clears valid flags and tx/rx state; bit period returns to 208 ticks.
// a stalled result holds the request register, which then stalls the input.
`default_nettype none

module full_duplex_uart_with_alarm #(
    parameter int RX_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic        rx_line,
    input  wire logic [7:0]  data_byte,
    input  wire logic [31:0] alarm_ticks,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             tx_line,
    output logic             tx_ready,
    output logic [7:0]       rx_count,
    output logic             read_valid,
    output logic [7:0]       read_byte,
    output logic             rejected
);

    logic [7:0]          period_reg;
    logic                req_valid_reg, req_valid_next;
    fdua_pkg::op_t       op_reg;
    logic                line_reg;
    logic [7:0]          data_reg;
    logic [31:0]         ticks_reg;
    logic                out_valid_reg, out_valid_next;
    logic                rvalid_reg;
    logic                rej_reg;
    logic                advance;
    logic                take;
    logic                rx_pop_ok;
    logic                tx_rej;
    logic [7:0]          rx_byte;
    fdua_pkg::item_ctl_t ctl;

    // handshake: a request moves on when the result slot is free or draining
    assign advance  = req_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && !advance;
    assign take     = in_valid && !in_stall;
    assign ctl      = '{fire: advance, op: op_reg};

    always_comb
    begin
        if (take)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end
        else
        begin
            req_valid_next = req_valid_reg;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // bit period register and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= fdua_pkg::BIT_PERIOD_RESET;
            req_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                period_reg <= cfg_data;
            end
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request payload register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg    <= fdua_pkg::op_t'(operation);
            line_reg  <= rx_line;
            data_reg  <= data_byte;
            ticks_reg <= alarm_ticks;
        end
    end

    // per-result flags
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rvalid_reg <= rx_pop_ok;
            rej_reg    <= tx_rej;
        end
    end

    fdua_tx u_tx (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .data_byte   (data_reg),
        .alarm_ticks (ticks_reg),
        .bit_period  (period_reg),
        .tx_level    (tx_line),
        .tx_idle     (tx_ready),
        .rejected    (tx_rej)
    );

    fdua_rx #(
        .RX_DEPTH (RX_DEPTH)
    ) u_rx (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .line       (line_reg),
        .bit_period (period_reg),
        .rx_count   (rx_count),
        .read_valid (rx_pop_ok),
        .read_byte  (rx_byte)
    );

    // state registers only change as a result is loaded, so they track it
    assign out_valid  = out_valid_reg;
    assign read_valid = rvalid_reg;
    assign read_byte  = rx_byte & {8{rvalid_reg}};
    assign rejected   = rej_reg;

endmodule

`default_nettype wire

[design/fdua_tx.sv]
// transmitter bit sequencer and busy alarm counter
`default_nettype none

module fdua_tx (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fdua_pkg::item_ctl_t  ctl,
    input  wire logic [7:0]           data_byte,
    input  wire logic [31:0]          alarm_ticks,
    input  wire logic [7:0]           bit_period,
    output logic                      tx_level,
    output logic                      tx_idle,
    output logic                      rejected
);

    fdua_pkg::tx_phase_t phase_reg, phase_next;
    logic [7:0]          shift_reg, shift_next;
    logic [3:0]          bits_left_reg, bits_left_next;
    logic [7:0]          timer_reg, timer_next;
    logic [31:0]         alarm_reg, alarm_next;
    logic                level_reg, level_next;
    logic [7:0]          full_reload;
    logic [31:0]         alarm_dec;
    logic                busy;

    // a period of zero wraps to 255 and so lasts 256 ticks
    assign full_reload = bit_period - 8'd1;
    assign alarm_dec   = alarm_reg - {31'd0, (alarm_reg != 32'd0)};
    assign busy        = (phase_reg != fdua_pkg::TX_IDLE);

    // next state for one request
    always_comb
    begin
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        timer_next     = timer_reg;
        alarm_next     = alarm_reg;
        level_next     = level_reg;
        rejected       = 1'b0;
        if (ctl.fire)
        begin
            case (ctl.op)
                fdua_pkg::OP_TICK:
                begin
                    case (phase_reg)
                        fdua_pkg::TX_IDLE:
                        begin
                        end
                        fdua_pkg::TX_ALARM:
                        begin
                            alarm_next = alarm_dec;
                            if (alarm_dec == 32'd0)
                            begin
                                phase_next = fdua_pkg::TX_IDLE;
                            end
                        end
                        default:
                        begin
                            if (timer_reg != 8'd0)
                            begin
                                timer_next = timer_reg - 8'd1;
                            end
                            else
                            begin
                                timer_next = full_reload;
                                case (phase_reg)
                                    fdua_pkg::TX_START:
                                    begin
                                        level_next     = 1'b0;
                                        bits_left_next = fdua_pkg::DATA_BITS;
                                        phase_next     = fdua_pkg::TX_DATA;
                                    end
                                    fdua_pkg::TX_DATA:
                                    begin
                                        level_next     = shift_reg[0];
                                        shift_next     = {1'b0, shift_reg[7:1]};
                                        bits_left_next = bits_left_reg - 4'd1;
                                        if (bits_left_reg == 4'd1)
                                        begin
                                            phase_next = fdua_pkg::TX_STOP;
                                        end
                                    end
                                    fdua_pkg::TX_STOP:
                                    begin
                                        level_next = 1'b1;
                                        phase_next = fdua_pkg::TX_FINISH;
                                    end
                                    default:
                                    begin
                                        // ready period over
                                        phase_next = fdua_pkg::TX_IDLE;
                                        timer_next = 8'd0;
                                    end
                                endcase
                            end
                        end
                    endcase
                end
                fdua_pkg::OP_SEND:
                begin
                    if (busy)
                    begin
                        rejected = 1'b1;
                    end
                    else
                    begin
                        shift_next = data_byte;
                        phase_next = fdua_pkg::TX_START;
                        timer_next = full_reload;
                    end
                end
                fdua_pkg::OP_ALARM:
                begin
                    if (busy)
                    begin
                        rejected = 1'b1;
                    end
                    else if (alarm_ticks != 32'd0)
                    begin
                        alarm_next = alarm_ticks;
                        phase_next = fdua_pkg::TX_ALARM;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= fdua_pkg::TX_IDLE;
            shift_reg     <= 8'd0;
            bits_left_reg <= 4'd0;
            timer_reg     <= 8'd0;
            alarm_reg     <= 32'd0;
            level_reg     <= 1'b1;
        end
        else
        begin
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            timer_reg     <= timer_next;
            alarm_reg     <= alarm_next;
            level_reg     <= level_next;
        end
    end

    assign tx_level = level_reg;
    assign tx_idle  = ~busy;

    // finishing a frame leaves the bit timer cleared for the next send
    a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == fdua_pkg::TX_IDLE) |-> (timer_reg == 8'd0))
        else $error("tx idle with bit timer running");

    // data phase always has bits outstanding
    a_data_bits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == fdua_pkg::TX_DATA) |-> (bits_left_reg != 4'd0))
        else $error("tx data phase with no bits left");

    // an alarm in progress never sits at zero
    a_alarm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == fdua_pkg::TX_ALARM) |-> (alarm_reg != 32'd0))
        else $error("alarm phase with zero count");

endmodule

`default_nettype wire

[design/fdua_rx.sv]
// receiver sampler and received byte ring
`default_nettype none

module fdua_rx #(
    parameter int RX_DEPTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fdua_pkg::item_ctl_t  ctl,
    input  wire logic                 line,
    input  wire logic [7:0]           bit_period,
    output logic [7:0]                rx_count,
    output logic                      read_valid,
    output logic [7:0]                read_byte
);

    localparam int PTR_W = $clog2(RX_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    fdua_pkg::rx_phase_t phase_reg, phase_next;
    logic [7:0]          timer_reg, timer_next;
    logic [7:0]          shift_reg, shift_next;
    logic [3:0]          bits_left_reg, bits_left_next;
    logic                prev_reg, prev_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [PTR_W-1:0]    head_adv;
    logic [PTR_W-1:0]    tail_adv;
    logic [7:0]          ring_mem [RX_DEPTH];
    logic [7:0]          rd_data_reg;
    logic [7:0]          full_reload;
    logic [7:0]          half_bits;
    logic [7:0]          half_reload;
    logic [CNT_W-1:0]    count_w;
    logic                push;
    logic                pop_ok;
    logic                tick;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] i);
        if (i == PTR_W'(RX_DEPTH - 1))
        begin
            ring_next = '0;
        end
        else
        begin
            ring_next = i + 1'b1;
        end
    endfunction

    // reload values; a half bit of zero acts as one tick
    assign full_reload = bit_period - 8'd1;
    assign half_bits   = {1'b0, bit_period[7:1]};
    assign half_reload = (half_bits == 8'd0) ? 8'd0 : (half_bits - 8'd1);
    assign head_adv    = ring_next(head_reg);
    assign tail_adv    = ring_next(tail_reg);
    assign tick        = ctl.fire && (ctl.op == fdua_pkg::OP_TICK);

    // sampler next state
    always_comb
    begin
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        prev_next      = prev_reg;
        push           = 1'b0;
        if (tick)
        begin
            prev_next = line;
            case (phase_reg)
                fdua_pkg::RX_IDLE:
                begin
                    if (prev_reg && !line)
                    begin
                        phase_next = fdua_pkg::RX_HALF;
                        timer_next = half_reload;
                    end
                end
                default:
                begin
                    if (timer_reg != 8'd0)
                    begin
                        timer_next = timer_reg - 8'd1;
                    end
                    else
                    begin
                        timer_next = full_reload;
                        case (phase_reg)
                            fdua_pkg::RX_HALF:
                            begin
                                phase_next     = fdua_pkg::RX_DATA;
                                bits_left_next = fdua_pkg::DATA_BITS;
                            end
                            fdua_pkg::RX_DATA:
                            begin
                                shift_next     = {line, shift_reg[7:1]};
                                bits_left_next = bits_left_reg - 4'd1;
                                if (bits_left_reg == 4'd1)
                                begin
                                    phase_next = fdua_pkg::RX_STOPWAIT;
                                end
                            end
                            default:
                            begin
                                // wait a bit period at a time for a high line
                                if (line)
                                begin
                                    push       = 1'b1;
                                    phase_next = fdua_pkg::RX_IDLE;
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // ring pointers; a push into a full ring drops the oldest byte
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        pop_ok    = 1'b0;
        if (push)
        begin
            head_next = head_adv;
            if (head_adv == tail_reg)
            begin
                tail_next = tail_adv;
            end
        end
        else if (ctl.fire && (ctl.op == fdua_pkg::OP_POP) && (head_reg != tail_reg))
        begin
            pop_ok    = 1'b1;
            tail_next = tail_adv;
        end
    end

    // occupancy from the pointers
    always_comb
    begin
        if (head_reg >= tail_reg)
        begin
            count_w = {1'b0, head_reg} - {1'b0, tail_reg};
        end
        else
        begin
            count_w = {1'b0, head_reg} + CNT_W'(RX_DEPTH) - {1'b0, tail_reg};
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= fdua_pkg::RX_IDLE;
            timer_reg     <= 8'd0;
            shift_reg     <= 8'd0;
            bits_left_reg <= 4'd0;
            prev_reg      <= 1'b1;
            head_reg      <= '0;
            tail_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            prev_reg      <= prev_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    // ring storage, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ring_mem[head_reg] <= shift_reg;
        end
        if (pop_ok)
        begin
            rd_data_reg <= ring_mem[tail_reg];
        end
    end

    assign rx_count   = 8'(count_w);
    assign read_valid = pop_ok;
    assign read_byte  = rd_data_reg;

    // sampler never counts more than a byte of data bits
    a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bits_left_reg <= fdua_pkg::DATA_BITS)
        else $error("rx bit counter beyond a byte");

    // a data phase always has bits outstanding
    a_data_bits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == fdua_pkg::RX_DATA) |-> (bits_left_reg != 4'd0))
        else $error("rx data phase with no bits left");

    // a pop on a non-empty ring moves the read pointer on
    a_pop_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.fire && (ctl.op == fdua_pkg::OP_POP) && (head_reg != tail_reg))
        |=> (tail_reg != $past(tail_reg)))
        else $error("pop on non-empty ring left the read pointer in place");

endmodule

`default_nettype wire
